// ----- rtl/sll_pkg.sv -----
// ----------------------------------------------------------------------------
// sll_pkg: shared types and constants of the script language lexer
// Token kinds, error kinds and the token record carried on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none
package sll_pkg;

  localparam int unsigned OutBits = 24;

  localparam logic [5:0] KindEof     = 6'd0;
  localparam logic [5:0] KindDot     = 6'd6;
  localparam logic [5:0] KindSlash   = 6'd10;
  localparam logic [5:0] KindBang    = 6'd12;
  localparam logic [5:0] KindEqual   = 6'd14;
  localparam logic [5:0] KindGreater = 6'd16;
  localparam logic [5:0] KindLess    = 6'd18;
  localparam logic [5:0] KindString  = 6'd20;
  localparam logic [5:0] KindNumber  = 6'd21;
  localparam logic [5:0] KindIdent   = 6'd22;
  localparam logic [5:0] KindKeyword = 6'd23;
  localparam logic [5:0] KindError   = 6'd40;

  localparam logic [1:0] ErrNone       = 2'd0;
  localparam logic [1:0] ErrUntermStr  = 2'd1;
  localparam logic [1:0] ErrUnexpected = 2'd2;

  typedef struct packed {
    logic [5:0]         kind;
    logic [1:0]         err;
    logic [OutBits-1:0] start;
    logic [OutBits-1:0] len;
    logic [OutBits-1:0] line;
    logic               last;
  } token_t;

endpackage
`default_nettype wire

// ----- rtl/sll_if.sv -----
// ----------------------------------------------------------------------------
// sll_byte_if / sll_token_if: valid/ready channels of the lexer
// Source bytes in, tokens out.
// ----------------------------------------------------------------------------
`default_nettype none
interface sll_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_input;
  modport source (output valid, source_byte, end_of_input, input ready);
  modport sink   (input valid, source_byte, end_of_input, output ready);
endinterface

interface sll_token_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [1:0]  error_kind;
  logic [23:0] token_start;
  logic [23:0] token_length;
  logic [23:0] token_line;
  logic        last_of_run;
  modport source (output valid, token_kind, error_kind, token_start, token_length,
                  token_line, last_of_run, input ready);
  modport sink   (input valid, token_kind, error_kind, token_start, token_length,
                  token_line, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/sll_keyword.sv -----
// ----------------------------------------------------------------------------
// sll_keyword: keyword match on the held identifier head
// Gives the token kind of an identifier from its first bytes and its length.
// ----------------------------------------------------------------------------
`default_nettype none
module sll_keyword
  import sll_pkg::*;
#(
  parameter int unsigned KeywordBytes = 6,
  parameter int unsigned CounterBits  = 24
) (
  input  wire logic [8*KeywordBytes-1:0] head_i,
  input  wire logic [CounterBits-1:0]    len_i,
  output      logic [5:0]                kind_o
);
  localparam int unsigned NumKw = 17;

  function automatic logic [63:0] kw_text(input int unsigned k);
    unique case (k)
      0:  kw_text = 64'h646e61;
      1:  kw_text = 64'h7373616c63;
      2:  kw_text = 64'h66696c65;
      3:  kw_text = 64'h65736c65;
      4:  kw_text = 64'h65736c6166;
      5:  kw_text = 64'h726f66;
      6:  kw_text = 64'h6e7566;
      7:  kw_text = 64'h6669;
      8:  kw_text = 64'h6c696e;
      9:  kw_text = 64'h726f;
      10: kw_text = 64'h746e697270;
      11: kw_text = 64'h6e7275746572;
      12: kw_text = 64'h7265707573;
      13: kw_text = 64'h73696874;
      14: kw_text = 64'h65757274;
      15: kw_text = 64'h726176;
      default: kw_text = 64'h656c696877;
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input int unsigned k);
    unique case (k)
      0, 5, 6, 8, 15:      kw_len = 4'd3;
      1, 4, 10, 12, 16:    kw_len = 4'd5;
      2, 3, 13, 14:        kw_len = 4'd4;
      7, 9:                kw_len = 4'd2;
      default:             kw_len = 4'd6;
    endcase
  endfunction

  logic [63:0] head_ext;
  assign head_ext = 64'(head_i);

  always_comb begin
    kind_o = KindIdent;
    for (int unsigned k = 0; k < NumKw; k++) begin
      if (len_i == CounterBits'(kw_len(k)) && head_ext == kw_text(k))
        kind_o = KindKeyword + 6'(k);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/script_language_lexer.sv -----
// ----------------------------------------------------------------------------
// script_language_lexer: streaming scanner for a small scripting language
//
// Input channel in_if carries one source byte per transfer, or an end flag.
// Output channel out_if carries tokens: kind, error kind, start, length, line
// and last_of_run, which marks the final token caused by one input byte.
// One byte leads to zero to three tokens; the end flag flushes any pending
// token and then gives EOF, after which the block is back in reset state.
// A byte is taken only when the output queue is empty or its last token
// leaves in that cycle; its tokens appear on the output in the next cycle.
// Throughput is one byte per cycle while each byte gives at most one token
// and out_if.ready stays high; the queue drains one token a cycle while
// out_if.ready is high, so bytes that give several tokens hold input off.
// Reset (rst_ni low) clears the scanner state (line 1, offset 0) and empties
// the queue. When the receiver stalls the queue fills and in_if.ready falls.
// ----------------------------------------------------------------------------
`default_nettype none
module script_language_lexer
  import sll_pkg::*;
#(
  parameter int unsigned COUNTER_BITS  = 24,
  parameter int unsigned KEYWORD_BYTES = 6
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sll_byte_if.sink   in_if,
  sll_token_if.source out_if
);
  localparam int unsigned CB = COUNTER_BITS;
  localparam int unsigned HB = 8 * KEYWORD_BYTES;
  localparam logic [CB-1:0] CMax = {CB{1'b1}};

  typedef enum logic [3:0] {
    MIdle, MSlash, MOpEq, MString, MNumber, MNumDot, MFraction, MIdent, MComment
  } mode_e;

  mode_e         mode_q, mode_d;
  logic [CB-1:0] pos_q, pos_d, start_q, start_d, line_q, line_d, len_q, len_d;
  logic [HB-1:0] head_q, head_d;
  logic [7:0]    pend_q, pend_d;

  token_t     tok [3];
  logic [1:0] ntok;

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
    return (v == CMax) ? CMax : v + CB'(1);
  endfunction

  function automatic logic [OutBits-1:0] clip(input logic [CB-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'(24'hFFFFFF)) ? 24'hFFFFFF : w[OutBits-1:0];
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] c, input logic eq);
    logic [5:0] b;
    unique case (c)
      8'h21:   b = KindBang;
      8'h3d:   b = KindEqual;
      8'h3e:   b = KindGreater;
      default: b = KindLess;
    endcase
    return b + 6'(eq);
  endfunction

  logic [7:0] c;
  logic       eoi, is_dig, is_alp;
  logic [5:0] id_kind;
  assign c      = in_if.source_byte;
  assign eoi    = in_if.end_of_input;
  assign is_dig = c >= 8'h30 && c <= 8'h39;
  assign is_alp = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;

  sll_keyword #(.KeywordBytes(KEYWORD_BYTES), .CounterBits(CB)) u_kw (
    .head_i(head_q), .len_i(len_q), .kind_o(id_kind)
  );

  // next-state and token generation for one accepted byte or end flag
  always_comb begin
    logic [5:0] single;
    logic       do_flush, do_begin;
    logic [CB-1:0] dot_sum;
    logic [CB:0]   dsum;
    mode_d  = mode_q;
    pos_d   = pos_q;
    start_d = start_q;
    line_d  = line_q;
    len_d   = len_q;
    head_d  = head_q;
    pend_d  = pend_q;
    ntok    = 2'd0;
    do_flush = 1'b0;
    do_begin = 1'b0;
    single  = 6'd0;
    dsum    = {1'b0, start_q} + {1'b0, len_q};
    dot_sum = (start_q == CMax || len_q == CMax || dsum[CB]) ? CMax : dsum[CB-1:0];
    for (int i = 0; i < 3; i++) begin
      tok[i] = '0;
      tok[i].line = clip(line_q);
    end
    if (eoi) begin
      do_flush = 1'b1;
    end else begin
      unique case (mode_q)
        MSlash: begin
          if (c == 8'h2f) mode_d = MComment;
          else begin do_flush = 1'b1; do_begin = 1'b1; end
        end
        MOpEq: begin
          if (c == 8'h3d) begin
            tok[0] = '{op_kind(pend_q, 1'b1), ErrNone, clip(start_q), 24'd2,
                       clip(line_q), 1'b0};
            ntok = 2'd1;
            mode_d = MIdle;
          end else begin do_flush = 1'b1; do_begin = 1'b1; end
        end
        MString: begin
          len_d = sat_inc(len_q);
          if (c == 8'h22) begin
            tok[0] = '{KindString, ErrNone, clip(start_q), clip(len_d), clip(line_q), 1'b0};
            ntok = 2'd1;
            mode_d = MIdle;
          end
        end
        MNumber: begin
          if (is_dig) len_d = sat_inc(len_q);
          else if (c == 8'h2e) mode_d = MNumDot;
          else begin do_flush = 1'b1; do_begin = 1'b1; end
        end
        MNumDot: begin
          if (is_dig) begin
            len_d = (len_q >= CMax - CB'(1)) ? CMax : len_q + CB'(2);
            mode_d = MFraction;
          end else begin do_flush = 1'b1; do_begin = 1'b1; end
        end
        MFraction: begin
          if (is_dig) len_d = sat_inc(len_q);
          else begin do_flush = 1'b1; do_begin = 1'b1; end
        end
        MIdent: begin
          if (is_alp || is_dig) begin
            for (int unsigned i = 0; i < KEYWORD_BYTES; i++)
              if (len_q == CB'(i)) head_d[8*i +: 8] = c;
            len_d = sat_inc(len_q);
          end else begin do_flush = 1'b1; do_begin = 1'b1; end
        end
        MComment: begin
          if (c == 8'h0a) begin
            line_d = sat_inc(line_q);
            mode_d = MIdle;
          end
        end
        default: do_begin = 1'b1;
      endcase
      pos_d = sat_inc(pos_q);
    end

    if (do_flush) begin
      unique case (mode_q)
        MSlash: begin
          tok[0] = '{KindSlash, ErrNone, clip(start_q), 24'd1, clip(line_q), 1'b0};
          ntok = 2'd1;
        end
        MOpEq: begin
          tok[0] = '{op_kind(pend_q, 1'b0), ErrNone, clip(start_q), 24'd1,
                     clip(line_q), 1'b0};
          ntok = 2'd1;
        end
        MString: begin
          tok[0] = '{KindError, ErrUntermStr, clip(start_q), clip(len_q), clip(line_q), 1'b0};
          ntok = 2'd1;
        end
        MNumber, MFraction: begin
          tok[0] = '{KindNumber, ErrNone, clip(start_q), clip(len_q), clip(line_q), 1'b0};
          ntok = 2'd1;
        end
        MNumDot: begin
          tok[0] = '{KindNumber, ErrNone, clip(start_q), clip(len_q), clip(line_q), 1'b0};
          tok[1] = '{KindDot, ErrNone, clip(dot_sum), 24'd1, clip(line_q), 1'b0};
          ntok = 2'd2;
        end
        MIdent: begin
          tok[0] = '{id_kind, ErrNone, clip(start_q), clip(len_q), clip(line_q), 1'b0};
          ntok = 2'd1;
        end
        default: ;
      endcase
      mode_d = MIdle;
    end

    if (eoi) begin
      tok[ntok] = '{KindEof, ErrNone, clip(pos_q), 24'd0, clip(line_q), 1'b0};
      ntok = ntok + 2'd1;
      mode_d = MIdle; pos_d = '0; start_d = '0; line_d = CB'(1);
      len_d = '0; head_d = '0; pend_d = '0;
    end else if (do_begin) begin
      mode_d = MIdle;
      unique case (c)
        8'h28: single = 6'd1;
        8'h29: single = 6'd2;
        8'h7b: single = 6'd3;
        8'h7d: single = 6'd4;
        8'h2c: single = 6'd5;
        8'h2e: single = 6'd6;
        8'h2d: single = 6'd7;
        8'h2b: single = 6'd8;
        8'h3b: single = 6'd9;
        8'h2a: single = 6'd11;
        default: single = 6'd0;
      endcase
      if (c == 8'h20 || c == 8'h0d || c == 8'h09) begin
      end else if (c == 8'h0a) begin
        line_d = sat_inc(line_q);
      end else if (c == 8'h2f || c == 8'h22 || c == 8'h21 || c == 8'h3d ||
                   c == 8'h3c || c == 8'h3e) begin
        mode_d  = (c == 8'h2f) ? MSlash : (c == 8'h22) ? MString : MOpEq;
        start_d = pos_q;
        len_d   = CB'(1);
        if (c != 8'h2f && c != 8'h22) pend_d = c;
      end else if (single != 6'd0) begin
        tok[ntok] = '{single, ErrNone, clip(pos_q), 24'd1, clip(line_q), 1'b0};
        ntok = ntok + 2'd1;
      end else if (is_dig || is_alp) begin
        mode_d  = is_dig ? MNumber : MIdent;
        start_d = pos_q;
        len_d   = CB'(1);
        if (is_alp) head_d = HB'(c);
      end else begin
        tok[ntok] = '{KindError, ErrUnexpected, clip(pos_q), 24'd1, clip(line_q), 1'b0};
        ntok = ntok + 2'd1;
      end
    end
    if (ntok != 2'd0) tok[ntok - 2'd1].last = 1'b1;
  end

  // output queue: holds up to three tokens, one leaves per cycle while ready
  token_t     fifo_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q;
  logic       in_fire, out_fire;

  assign in_if.ready  = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_fire);
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_if.valid = cnt_q != 3'd0;
  assign out_fire     = out_if.valid && out_if.ready;

  assign out_if.token_kind   = fifo_q[rd_q].kind;
  assign out_if.error_kind   = fifo_q[rd_q].err;
  assign out_if.token_start  = fifo_q[rd_q].start;
  assign out_if.token_length = fifo_q[rd_q].len;
  assign out_if.token_line   = fifo_q[rd_q].line;
  assign out_if.last_of_run  = fifo_q[rd_q].last;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < 3; i++)
        if (2'(i) < ntok) fifo_q[wr_q + 2'(i)] <= tok[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MIdle; pos_q <= '0; start_q <= '0; line_q <= CB'(1);
      len_q <= '0; head_q <= '0; pend_q <= '0;
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      if (in_fire) begin
        mode_q <= mode_d; pos_q <= pos_d; start_q <= start_d; line_q <= line_d;
        len_q <= len_d; head_q <= head_d; pend_q <= pend_d;
        wr_q <= wr_q + ntok;
      end
      if (out_fire) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + (in_fire ? 3'(ntok) : 3'd0) - (out_fire ? 3'd1 : 3'd0);
    end
  end

  // queue never holds more than three tokens
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd3)
    else $error("token queue overflow");
  // end flag always puts the scanner back to its reset line
  a_eoi_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_if.end_of_input |=> line_q == CB'(1) && pos_q == '0)
    else $error("scanner not reset after end of input");
  // read and write pointers are equal when the queue is empty
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 3'd0 |-> rd_q == wr_q)
    else $error("queue pointers out of step");

endmodule
`default_nettype wire
